>>> rtl/arpc_pkg.sv
`timescale 1ns / 1ps

package arpc_pkg;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int ACT_W = 2;
    localparam int CNT_W = 16;

    // action codes carried on the input tuser
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

    localparam logic [CNT_W-1:0] FLUSH_PERIOD_RESET = 16'd60;
    localparam logic [CNT_W-1:0] COUNTER_MAX        = 16'hFFFF;

    // search word handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic [ACT_W-1:0] action;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic             hit;
        logic [MAC_W-1:0] found;
    } probe_t;

    // table maintenance broadcast to every cell
    typedef struct packed {
        logic             flush;
        logic             write;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } cell_cmd_t;

endpackage

>>> rtl/arp_cache_table.sv
`timescale 1ns / 1ps
// ARP cache: maps IPv4 addresses to MAC addresses in a table of ENTRIES slots.
// Input stream: s_tuser carries the action (lookup, add/update, tick),
// s_tdata carries the IP address and the MAC to store. Every input word
// gives exactly one output word: m_tuser is the hit flag, m_tdata the MAC
// found on a lookup hit (zero otherwise).
// flush_period is written on the cfg channel (cfg_ready is always high)
// and should only be changed while the table is idle.
// Each word walks down a row of ENTRIES cells, one cell per cycle, each cell
// holding one slot; an add that misses then fills the slot at the
// round-robin pointer, a lookup miss past the flush period clears all slots.
// One word is in flight at a time; s_tready rises again in the same cycle
// as the output word is loaded, so no new word is taken before the last
// one has finished its walk through the cell row and reached the output.
// After reset all slots are empty, the pointer and flush counter are zero
// and the flush period is 60. A stalled m_tready holds the output word; the
// next input word is still taken and waits at the end of its walk until the
// output register frees up.
module arp_cache_table
    import arpc_pkg::*;
#(
    parameter int ENTRIES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // ip_addr[31:0], entry_mac[79:32]
    input  logic [1:0]  s_tuser,   // action[1:0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // found_mac[47:0]
    output logic        m_tuser,   // hit
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // flush_period
);

    localparam int PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t           state_reg;
    logic             launch_reg;
    logic             out_valid_reg;
    logic             cmd_flush_reg;
    logic             cmd_write_reg;
    logic [PTR_W-1:0] ptr_reg;
    logic [CNT_W-1:0] counter_reg;
    logic [CNT_W-1:0] period_reg;

    logic [ACT_W-1:0] action_reg;
    logic [IP_W-1:0]  ip_reg;
    logic [MAC_W-1:0] mac_reg;
    logic             res_hit_reg;
    logic [MAC_W-1:0] res_found_reg;
    logic             out_hit_reg;
    logic [MAC_W-1:0] out_mac_reg;

    logic             in_fire;
    logic             done_fire;
    cell_cmd_t        cmd;
    probe_t           probe_chain [0:ENTRIES];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_mac_reg;
    assign m_tuser   = out_hit_reg;

    // broadcast maintenance to the cells
    assign cmd.flush = cmd_flush_reg;
    assign cmd.write = cmd_write_reg;
    assign cmd.ip    = ip_reg;
    assign cmd.mac   = mac_reg;

    // word entering the first cell
    assign probe_chain[0].valid  = launch_reg;
    assign probe_chain[0].action = action_reg;
    assign probe_chain[0].ip     = ip_reg;
    assign probe_chain[0].mac    = mac_reg;
    assign probe_chain[0].hit    = 1'b0;
    assign probe_chain[0].found  = '0;

    // row of table cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        arpc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .probe_in  (probe_chain[i]),
            .probe_out (probe_chain[i+1]),
            .cmd       (cmd),
            .sel       (ptr_reg == PTR_W'(i))
        );
    end

    // control state machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cmd_flush_reg <= 1'b0;
            cmd_write_reg <= 1'b0;
            ptr_reg       <= '0;
            counter_reg   <= '0;
            period_reg    <= FLUSH_PERIOD_RESET;
        end
        else
        begin
            launch_reg    <= 1'b0;
            cmd_flush_reg <= 1'b0;
            cmd_write_reg <= 1'b0;
            if (cfg_valid)
            begin
                period_reg <= cfg_data;
            end
            // output word loaded or drained
            if (done_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            // step the round-robin pointer once the new slot is written
            if (cmd_write_reg)
            begin
                if (ptr_reg == PTR_W'(ENTRIES - 1))
                begin
                    ptr_reg <= '0;
                end
                else
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        launch_reg <= 1'b1;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (probe_chain[ENTRIES].valid)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (done_fire)
                    begin
                        state_reg <= ST_IDLE;
                        case (action_reg)
                            ACT_LOOKUP:
                            begin
                                if (!res_hit_reg && (counter_reg >= period_reg))
                                begin
                                    cmd_flush_reg <= 1'b1;
                                    counter_reg   <= '0;
                                end
                            end
                            ACT_ADD:
                            begin
                                if (!res_hit_reg)
                                begin
                                    cmd_write_reg <= 1'b1;
                                end
                            end
                            ACT_TICK:
                            begin
                                if (counter_reg != COUNTER_MAX)
                                begin
                                    counter_reg <= counter_reg + 1'b1;
                                end
                            end
                            default:
                            begin
                                counter_reg <= counter_reg;
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // item, scan result and output word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            action_reg <= s_tuser;
            ip_reg     <= s_tdata[31:0];
            mac_reg    <= s_tdata[79:32];
        end
        if ((state_reg == ST_SCAN) && probe_chain[ENTRIES].valid)
        begin
            res_hit_reg   <= probe_chain[ENTRIES].hit;
            res_found_reg <= probe_chain[ENTRIES].found;
        end
        if (done_fire)
        begin
            out_hit_reg <= res_hit_reg;
            out_mac_reg <= res_found_reg;
        end
    end

endmodule

>>> rtl/arpc_cell.sv
`timescale 1ns / 1ps

module arpc_cell
    import arpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  probe_t    probe_in,
    output probe_t    probe_out,
    input  cell_cmd_t cmd,
    input  logic      sel
);

    logic             ent_valid_reg;
    logic [IP_W-1:0]  ent_ip_reg;
    logic [MAC_W-1:0] ent_mac_reg;
    logic             probe_valid_reg;
    probe_t           probe_data_reg;
    probe_t           probe_next;
    logic             match;

    // compare the passing word against this entry
    assign match = ent_valid_reg && (ent_ip_reg == probe_in.ip);

    // first hit wins on lookup, any hit counts on add
    always_comb
    begin
        probe_next = probe_in;
        case (probe_in.action)
            ACT_LOOKUP:
            begin
                if (match && !probe_in.hit)
                begin
                    probe_next.hit   = 1'b1;
                    probe_next.found = ent_mac_reg;
                end
            end
            ACT_ADD:
            begin
                if (match)
                begin
                    probe_next.hit = 1'b1;
                end
            end
            default:
            begin
                probe_next = probe_in;
            end
        endcase
    end

    // entry valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg   <= 1'b0;
            probe_valid_reg <= 1'b0;
        end
        else
        begin
            probe_valid_reg <= probe_in.valid;
            if (cmd.flush)
            begin
                ent_valid_reg <= 1'b0;
            end
            else if (cmd.write && sel)
            begin
                ent_valid_reg <= 1'b1;
            end
        end
    end

    // entry contents and the word handed to the next cell
    always_ff @(posedge clk)
    begin
        probe_data_reg <= probe_next;
        if (cmd.write && sel)
        begin
            ent_ip_reg  <= cmd.ip;
            ent_mac_reg <= cmd.mac;
        end
        else if (probe_in.valid && (probe_in.action == ACT_ADD) && match)
        begin
            ent_mac_reg <= probe_in.mac;
        end
    end

    always_comb
    begin
        probe_out       = probe_data_reg;
        probe_out.valid = probe_valid_reg;
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import arpc_pkg::*;

    localparam int ENTRIES      = 8;
    localparam int LATENCY      = ENTRIES + 2;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int PHASE_WORDS  = 125;
    localparam int PHASES       = 6;
    localparam int POOL_SIZE    = 12;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] mac;
    } reply_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic             has_fixed;
        reply_t           fixed_reply;
    } stim_row_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;   // ip_addr[31:0], entry_mac[79:32]
    logic [1:0]  s_tuser   = '0;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;          // found_mac[47:0]
    logic        m_tuser;          // hit
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;   // flush_period

    // shadow copy of the table
    logic             slot_valid [ENTRIES];
    logic [IP_W-1:0]  slot_ip    [ENTRIES];
    logic [MAC_W-1:0] slot_mac   [ENTRIES];
    int unsigned      fill_ptr;
    logic [CNT_W-1:0] tick_count;
    logic [CNT_W-1:0] flush_period;

    reply_t           pending_replies [$];
    stim_row_t        directed_rows [$];
    logic [IP_W-1:0]  ip_pool [POOL_SIZE];
    int               error_count = 0;
    bit               calm = 1'b0;

    arp_cache_table #(
        .ENTRIES(ENTRIES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // table state after reset
    function automatic void clear_shadow_table();
        int k;
        for (k = 0; k < ENTRIES; k++)
        begin
            slot_valid[k] = 1'b0;
            slot_ip[k]    = '0;
            slot_mac[k]   = '0;
        end
        fill_ptr     = 0;
        tick_count   = '0;
        flush_period = FLUSH_PERIOD_RESET;
    endfunction

    // expected reply for one word, and the table update it causes
    function automatic reply_t predict_arp_reply(input logic [ACT_W-1:0] act,
                                                 input logic [IP_W-1:0]  ip,
                                                 input logic [MAC_W-1:0] mac);
        reply_t r;
        int     k;
        r = '0;
        case (act)
            ACT_LOOKUP:
            begin
                // first matching slot wins
                for (k = 0; k < ENTRIES; k++)
                begin
                    if (!r.hit && slot_valid[k] && slot_ip[k] == ip)
                    begin
                        r.hit = 1'b1;
                        r.mac = slot_mac[k];
                    end
                end
                // miss past the flush period empties the table
                if (!r.hit && tick_count >= flush_period)
                begin
                    for (k = 0; k < ENTRIES; k++)
                        slot_valid[k] = 1'b0;
                    tick_count = '0;
                end
            end
            ACT_ADD:
            begin
                for (k = 0; k < ENTRIES; k++)
                begin
                    if (slot_valid[k] && slot_ip[k] == ip)
                    begin
                        slot_mac[k] = mac;
                        r.hit = 1'b1;
                    end
                end
                // new address goes to the round-robin slot
                if (!r.hit)
                begin
                    slot_ip[fill_ptr]    = ip;
                    slot_mac[fill_ptr]   = mac;
                    slot_valid[fill_ptr] = 1'b1;
                    fill_ptr = (fill_ptr + 1) % ENTRIES;
                end
            end
            ACT_TICK:
            begin
                if (tick_count != COUNTER_MAX)
                    tick_count = tick_count + 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_row(input logic [ACT_W-1:0] act,
                                    input logic [IP_W-1:0]  ip,
                                    input logic [MAC_W-1:0] mac,
                                    input logic             has_fixed,
                                    input logic             hit,
                                    input logic [MAC_W-1:0] found);
        stim_row_t row;
        row.action          = act;
        row.ip              = ip;
        row.mac             = mac;
        row.has_fixed       = has_fixed;
        row.fixed_reply.hit = hit;
        row.fixed_reply.mac = found;
        directed_rows.push_back(row);
    endfunction

    // one input word; the expectation is queued when it is taken
    task automatic send_word(input logic [ACT_W-1:0] act,
                             input logic [IP_W-1:0]  ip,
                             input logic [MAC_W-1:0] mac,
                             input logic             has_fixed,
                             input reply_t           fixed_reply);
        int     gap;
        reply_t model_reply;
        gap = idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {mac, ip};
        do @(posedge clk); while (!s_tready);
        model_reply = predict_arp_reply(act, ip, mac);
        pending_replies.push_back(has_fixed ? fixed_reply : model_reply);
    endtask

    // hold off the sender until every reply is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_flush_period(input logic [CNT_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        flush_period = value;
    endtask

    // random word, mostly on a small set of addresses so hits and evictions occur
    task automatic send_random_word();
        logic [ACT_W-1:0] act;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        int               r;
        r = $urandom_range(0, 99);
        if (r < 40)
            act = ACT_LOOKUP;
        else if (r < 75)
            act = ACT_ADD;
        else if (r < 95)
            act = ACT_TICK;
        else
            act = ACT_UNUSED;
        if ($urandom_range(0, 99) < 80)
            ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            ip = $urandom;
        r = $urandom_range(0, 99);
        if (r < 5)
            mac = '1;
        else if (r < 10)
            mac = '0;
        else
        begin
            mac[47:32] = 16'($urandom_range(0, 16'hFFFF));
            mac[31:0]  = $urandom;
        end
        send_word(act, ip, mac, 1'b0, '0);
    endtask

    // output side: random stalls, compare each word with the oldest expectation
    initial
    begin : output_check
        int     stall_left;
        reply_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("unexpected output word: hit %0d found_mac %h", m_tuser, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (m_tuser !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, m_tuser);
                        error_count++;
                    end
                    if (m_tdata !== want.mac)
                    begin
                        $error("found_mac: expected %h, got %h", want.mac, m_tdata);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = idle_len();
                m_tready <= (stall_left == 0);
            end
        end
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("arp_cache_table verification failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [CNT_W-1:0] periods [PHASES];
        int               phase;
        int               n;
        int               k;

        clear_shadow_table();
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (k = 2; k < POOL_SIZE; k++)
            ip_pool[k] = $urandom;

        // directed words: empty table, extremes, update, tick, unused action, wrap
        add_row(ACT_LOOKUP, 32'h0000_0000, 48'h0000_0000_0000, 1'b1, 1'b0, 48'h0);
        add_row(ACT_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 48'h0);
        add_row(ACT_ADD,    32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 48'h0);
        add_row(ACT_ADD,    32'h0000_0000, 48'h0000_0000_0000, 1'b1, 1'b0, 48'h0);
        add_row(ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF);
        add_row(ACT_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 48'h0);
        add_row(ACT_ADD,    32'hFFFF_FFFF, 48'h0123_4567_89AB, 1'b1, 1'b1, 48'h0);
        add_row(ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b0, 1'b0, 48'h0);
        add_row(ACT_TICK,   32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 48'h0);
        add_row(ACT_UNUSED, 32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA, 1'b1, 1'b0, 48'h0);
        add_row(ACT_UNUSED, 32'h5555_5555, 48'h5555_5555_5555, 1'b1, 1'b0, 48'h0);
        for (k = 1; k <= ENTRIES; k++)
            add_row(ACT_ADD, 32'hC0A8_0000 + 32'(k), 48'h0200_0000_0000 + 48'(k),
                    1'b0, 1'b0, 48'h0);
        add_row(ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b0, 1'b0, 48'h0);
        add_row(ACT_LOOKUP, 32'h0000_0000, 48'h0, 1'b0, 1'b0, 48'h0);
        add_row(ACT_LOOKUP, 32'hC0A8_0000 + 32'(ENTRIES), 48'h0, 1'b0, 1'b0, 48'h0);
        add_row(ACT_TICK,   32'h0000_0000, 48'h0, 1'b0, 1'b0, 48'h0);

        // reset
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].action, directed_rows[i].ip, directed_rows[i].mac,
                      directed_rows[i].has_fixed, directed_rows[i].fixed_reply);

        // random phases over several flush periods, zero and both extremes among them
        periods[0] = 16'd1;
        periods[1] = 16'd0;
        periods[2] = COUNTER_MAX;
        periods[3] = 16'd3;
        periods[4] = CNT_W'($urandom_range(2, 40));
        periods[5] = FLUSH_PERIOD_RESET;
        for (phase = 0; phase < PHASES; phase++)
        begin
            write_flush_period(periods[phase]);
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if (n == PHASE_WORDS / 2)
                    wait_idle();
                if (n % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                send_random_word();
            end
        end
        calm = 1'b0;

        wait_idle();
        if (error_count == 0)
            $display("arp_cache_table verification clean");
        else
            $display("arp_cache_table verification failed");
        $finish;
    end

endmodule

>>> files.f
rtl/arpc_pkg.sv
rtl/arpc_cell.sv
rtl/arp_cache_table.sv
tb/sv/testbench.sv
